// File: rtl/sgba_pkg.sv
// ----------------------------------------------------------------------------
// sgba_pkg
// Shared types and constants of the sorted group-by aggregator.
// ----------------------------------------------------------------------------
package sgba_pkg;

    localparam int LANES        = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int FN_BITS      = 3;
    localparam int KEY_W        = 64;
    localparam int VAL_W        = 32;
    localparam int ACC_W        = 64;
    localparam int ROWS_W       = 32;
    localparam int IN_W         = KEY_W + LANES * VAL_W;
    localparam int OUT_W        = KEY_W + ROWS_W + LANES * ACC_W;
    localparam int DIV_W        = ACC_W + 8;
    localparam int DIV_CNT_W    = 7;

    localparam logic [FN_BITS-1:0] FN_SUM   = 3'd0;
    localparam logic [FN_BITS-1:0] FN_AVG   = 3'd1;
    localparam logic [FN_BITS-1:0] FN_MAX   = 3'd2;
    localparam logic [FN_BITS-1:0] FN_MIN   = 3'd3;
    localparam logic [FN_BITS-1:0] FN_COUNT = 3'd4;
    localparam logic [FN_BITS-1:0] FN_OFF   = 3'd5;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    // per-lane row control
    typedef struct packed {
        logic load;   // open a new group with this row
        logic upd;    // fold this row into the open group
    } lane_ctrl_t;

endpackage

// File: rtl/sgba_lane.sv
// ----------------------------------------------------------------------------
// sgba_lane
// One aggregate lane: accumulator for sum, max or min of the open group.
// ----------------------------------------------------------------------------
module sgba_lane
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sgba_pkg::lane_ctrl_t                  ctrl,
    input  logic [sgba_pkg::FN_BITS-1:0]          fn,
    input  logic signed [sgba_pkg::VAL_W-1:0]     value,
    output logic signed [sgba_pkg::ACC_W-1:0]     acc
);

    logic signed [sgba_pkg::ACC_W-1:0] acc_reg;
    logic signed [sgba_pkg::ACC_W-1:0] acc_next;
    logic signed [sgba_pkg::ACC_W-1:0] v_ext;
    logic signed [sgba_pkg::ACC_W:0]   sum_wide;
    logic signed [sgba_pkg::ACC_W-1:0] sum_sat;

    assign v_ext    = sgba_pkg::ACC_W'(value);
    assign sum_wide = {acc_reg[sgba_pkg::ACC_W-1], acc_reg} + {v_ext[sgba_pkg::ACC_W-1], v_ext};

    always_comb
    begin
        if (sum_wide[sgba_pkg::ACC_W] != sum_wide[sgba_pkg::ACC_W-1])
            sum_sat = sum_wide[sgba_pkg::ACC_W] ? sgba_pkg::ACC_MIN : sgba_pkg::ACC_MAX;
        else
            sum_sat = sum_wide[sgba_pkg::ACC_W-1:0];
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load)
            acc_next = v_ext;
        else if (ctrl.upd)
        begin
            case (fn)
                sgba_pkg::FN_SUM, sgba_pkg::FN_AVG: acc_next = sum_sat;
                sgba_pkg::FN_MAX: if (v_ext > acc_reg) acc_next = v_ext;
                sgba_pkg::FN_MIN: if (v_ext < acc_reg) acc_next = v_ext;
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: rtl/sgba_avg.sv
// ----------------------------------------------------------------------------
// sgba_avg
// Bit-serial average: sum * 256 / rows, truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module sgba_avg
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [sgba_pkg::ACC_W-1:0]     sum,
    input  logic [sgba_pkg::ROWS_W-1:0]           rows,
    output logic                                  busy,
    output logic signed [sgba_pkg::ACC_W-1:0]     result
);

    logic [sgba_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [sgba_pkg::DIV_W-1:0]     quo_reg;
    logic [sgba_pkg::ROWS_W-1:0]    rem_reg;
    logic [sgba_pkg::ROWS_W-1:0]    rows_reg;
    logic                           neg_reg;
    logic [sgba_pkg::ACC_W-1:0]     mag;
    logic [sgba_pkg::ROWS_W:0]      rem_sh;
    logic [sgba_pkg::ROWS_W:0]      diff;
    logic                           ge;

    assign mag    = sum[sgba_pkg::ACC_W-1] ? (~sum + 1'b1) : sum;
    assign rem_sh = {rem_reg, quo_reg[sgba_pkg::DIV_W-1]};
    assign diff   = rem_sh - {1'b0, rows_reg};
    assign ge     = (rem_sh >= {1'b0, rows_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= sgba_pkg::DIV_CNT_W'(sgba_pkg::DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= {mag, 8'b0};
            rem_reg  <= '0;
            rows_reg <= rows;
            neg_reg  <= sum[sgba_pkg::ACC_W-1];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[sgba_pkg::ROWS_W-1:0] : rem_sh[sgba_pkg::ROWS_W-1:0];
            quo_reg <= {quo_reg[sgba_pkg::DIV_W-2:0], ge};
        end
    end

    assign busy = (cnt_reg != '0);

    // clamp the magnitude into the signed range
    always_comb
    begin
        if (neg_reg)
        begin
            if ((|quo_reg[sgba_pkg::DIV_W-1:sgba_pkg::ACC_W]) ||
                (quo_reg[sgba_pkg::ACC_W-1] && (|quo_reg[sgba_pkg::ACC_W-2:0])))
                result = sgba_pkg::ACC_MIN;
            else
                result = ~quo_reg[sgba_pkg::ACC_W-1:0] + 1'b1;
        end
        else
        begin
            if (|quo_reg[sgba_pkg::DIV_W-1:sgba_pkg::ACC_W-1])
                result = sgba_pkg::ACC_MAX;
            else
                result = quo_reg[sgba_pkg::ACC_W-1:0];
        end
    end

endmodule

// File: rtl/sorted_group_by_aggregator.sv
// ----------------------------------------------------------------------------
// sorted_group_by_aggregator
// Per-group SUM/AVG/MAX/MIN/COUNT over key-sorted rows, four lanes wide.
// ----------------------------------------------------------------------------
// A row closing no group leaves the input ready for the next cycle's row. A key
// change snapshots the old group and starts the average dividers, whose result
// is then registered; an end of stream alone, or one row's second group, first
// passes a load state that snapshots it. Each group waits in the output register
// until taken; input reopens next unless a second group is pending.
// Reset (rst_n low, asynchronous) closes any open group and sets every lane off.
module sorted_group_by_aggregator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sgba_pkg::IN_W-1:0]            s_tdata,  // group_key, lane0..3_value
    input  logic                                 s_tlast,  // end_of_stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sgba_pkg::OUT_W-1:0]           m_tdata,  // out_key, group_rows, lane0..3_result
    output logic                                 m_tlast,  // last_of_run
    input  logic                                 cfg_we,
    input  logic [sgba_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sgba_pkg::FN_BITS-1:0]         cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_OUT} state_t;

    state_t                                state_reg;
    logic [sgba_pkg::FN_BITS-1:0]          fn_reg [sgba_pkg::LANES];
    logic [sgba_pkg::KEY_W-1:0]            key_reg;
    logic                                  open_reg;
    logic [sgba_pkg::ROWS_W-1:0]           rows_reg;
    logic                                  pend2_reg;
    logic                                  div_start_reg;
    logic [sgba_pkg::KEY_W-1:0]            job_key_reg;
    logic [sgba_pkg::ROWS_W-1:0]           job_rows_reg;
    logic                                  job_last_reg;
    logic signed [sgba_pkg::ACC_W-1:0]     job_acc_reg [sgba_pkg::LANES];
    logic [sgba_pkg::OUT_W-1:0]            out_data_reg;
    logic                                  out_last_reg;

    logic                                  accept;
    logic [sgba_pkg::KEY_W-1:0]            row_key;
    logic                                  emit1;
    logic                                  start_new;
    sgba_pkg::lane_ctrl_t                  lane_ctrl;
    logic signed [sgba_pkg::ACC_W-1:0]     acc      [sgba_pkg::LANES];
    logic signed [sgba_pkg::ACC_W-1:0]     avg_res  [sgba_pkg::LANES];
    logic [sgba_pkg::LANES-1:0]            div_busy;
    logic [sgba_pkg::LANES*sgba_pkg::ACC_W-1:0] lane_res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign row_key   = s_tdata[sgba_pkg::KEY_W-1:0];
    assign emit1     = open_reg && (row_key != key_reg);
    assign start_new = !open_reg || emit1;

    assign lane_ctrl.load = accept && start_new;
    assign lane_ctrl.upd  = accept && !start_new;

    for (genvar g = 0; g < sgba_pkg::LANES; g++)
    begin : g_lane
        sgba_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .fn    (fn_reg[g]),
            .value (s_tdata[sgba_pkg::KEY_W + g*sgba_pkg::VAL_W +: sgba_pkg::VAL_W]),
            .acc   (acc[g])
        );

        sgba_avg u_avg
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (div_start_reg),
            .sum    (job_acc_reg[g]),
            .rows   (job_rows_reg),
            .busy   (div_busy[g]),
            .result (avg_res[g])
        );

        // merge: pick the lane result under the selector in force now
        always_comb
        begin
            case (fn_reg[g])
                sgba_pkg::FN_SUM, sgba_pkg::FN_MAX, sgba_pkg::FN_MIN:
                    lane_res[g*sgba_pkg::ACC_W +: sgba_pkg::ACC_W] = job_acc_reg[g];
                sgba_pkg::FN_AVG:
                    lane_res[g*sgba_pkg::ACC_W +: sgba_pkg::ACC_W] = avg_res[g];
                sgba_pkg::FN_COUNT:
                    lane_res[g*sgba_pkg::ACC_W +: sgba_pkg::ACC_W] =
                        sgba_pkg::ACC_W'(job_rows_reg);
                default:
                    lane_res[g*sgba_pkg::ACC_W +: sgba_pkg::ACC_W] = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sgba_pkg::LANES; i++)
                fn_reg[i] <= sgba_pkg::FN_OFF;
        end
        else if (cfg_we)
        begin
            fn_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_reg       <= '0;
            open_reg      <= 1'b0;
            rows_reg      <= '0;
            pend2_reg     <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (start_new)
                        begin
                            key_reg  <= row_key;
                            rows_reg <= 32'd1;
                        end
                        else if (rows_reg != '1)
                        begin
                            rows_reg <= rows_reg + 1'b1;
                        end
                        open_reg  <= !s_tlast;
                        pend2_reg <= emit1 && s_tlast;
                        if (emit1)
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end
                        else if (s_tlast)
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (!div_start_reg && (div_busy == '0))
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        pend2_reg <= 1'b0;
                        state_reg <= pend2_reg ? ST_LOAD : ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // job snapshot: the old group on a key change, the live group otherwise
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && emit1)
        begin
            job_key_reg  <= key_reg;
            job_rows_reg <= rows_reg;
            job_last_reg <= !s_tlast;
            for (int i = 0; i < sgba_pkg::LANES; i++)
                job_acc_reg[i] <= acc[i];
        end
        else if (state_reg == ST_LOAD)
        begin
            job_key_reg  <= key_reg;
            job_rows_reg <= rows_reg;
            job_last_reg <= 1'b1;
            for (int i = 0; i < sgba_pkg::LANES; i++)
                job_acc_reg[i] <= acc[i];
        end
        if (state_reg == ST_DIV && !div_start_reg && (div_busy == '0))
        begin
            out_data_reg <= {lane_res, job_rows_reg, job_key_reg};
            out_last_reg <= job_last_reg;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/sgba_checker.sv
// ----------------------------------------------------------------------------
// sgba_checker
// Port-level checks of the sorted group-by aggregator.
// ----------------------------------------------------------------------------
module sgba_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sgba_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          m_tlast
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // no row taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("row taken while result pending");

    // end of stream always forces an emission
    a_eos_emits: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("end of stream did not close the group");

    // no result directly follows a taken last-of-run result
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("extra result after last of run");

endmodule

bind sorted_group_by_aggregator sgba_checker u_sgba_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted group-by aggregator: runs of rows of
// one key are streamed in under random idling and back-pressure, and every
// emitted group is checked field by field against a cycle-free aggregate model.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [sgba_pkg::FN_BITS-1:0] FN_SPARE6 = 3'd6;
    localparam logic [sgba_pkg::FN_BITS-1:0] FN_SPARE7 = 3'd7;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic [63:0] key;
        logic [31:0] rows;
        longint      lane_res [sgba_pkg::LANES];
        logic        last;
    } group_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [sgba_pkg::IN_W-1:0] s_tdata;   // group_key, lane0..3_value
    logic s_tlast;                        // end_of_stream
    logic m_tvalid;
    logic m_tready;
    logic [sgba_pkg::OUT_W-1:0] m_tdata;  // out_key, group_rows, lane0..3_result
    logic m_tlast;                        // last_of_run
    logic cfg_we;
    logic [sgba_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [sgba_pkg::FN_BITS-1:0] cfg_data;

    // model state
    logic [sgba_pkg::FN_BITS-1:0] lane_fn [sgba_pkg::LANES];
    logic [63:0] grp_key;
    logic        grp_open;
    logic [31:0] grp_rows;
    longint      grp_acc [sgba_pkg::LANES];

    group_result_t pending_groups [$];
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int mismatches;
    int fail_cnt;

    sorted_group_by_aggregator uut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #30ms;
        $display("[sorted_group_by_aggregator] ERROR");
        $finish;
    end

    function automatic longint sat_add(longint a, longint b);
        if (b > 0 && a > I64_MAX - b)
            return I64_MAX;
        if (b < 0 && a < I64_MIN - b)
            return I64_MIN;
        return a + b;
    endfunction

    // 8 fraction bits, truncated toward zero
    function automatic longint fixed_mean(longint total, logic [31:0] rows);
        longint n, q, r, fr;
        n  = (rows == 0) ? 64'sd1 : longint'({32'b0, rows});
        q  = total / n;
        r  = total % n;
        fr = (r * 256) / n;
        if (q > I64_MAX / 256)
            return I64_MAX;
        if (q < I64_MIN / 256)
            return I64_MIN;
        return sat_add(q * 256, fr);
    endfunction

    function automatic group_result_t close_group(logic last);
        group_result_t g;
        g.key  = grp_key;
        g.rows = grp_rows;
        g.last = last;
        for (int i = 0; i < sgba_pkg::LANES; i++)
        begin
            case (lane_fn[i])
                sgba_pkg::FN_SUM, sgba_pkg::FN_MAX, sgba_pkg::FN_MIN:
                    g.lane_res[i] = grp_acc[i];
                sgba_pkg::FN_AVG:
                    g.lane_res[i] = fixed_mean(grp_acc[i], grp_rows);
                sgba_pkg::FN_COUNT:
                    g.lane_res[i] = longint'({32'b0, grp_rows});
                default:
                    g.lane_res[i] = 0;
            endcase
        end
        return g;
    endfunction

    // append an expected group to the tail of the pending list
    function automatic void queue_group(group_result_t g);
        pending_groups = {pending_groups, g};
    endfunction

    task automatic fold_row(logic [63:0] key, logic [31:0] vals [sgba_pkg::LANES], logic eos);
        longint v;
        if (grp_open && key != grp_key)
        begin
            queue_group(close_group(!eos));
            grp_open = 1'b0;
        end
        if (!grp_open)
        begin
            grp_key  = key;
            grp_rows = 1;
            for (int i = 0; i < sgba_pkg::LANES; i++)
                grp_acc[i] = longint'(signed'(vals[i]));
            grp_open = 1'b1;
        end
        else
        begin
            if (grp_rows != 32'hFFFF_FFFF)
                grp_rows++;
            for (int i = 0; i < sgba_pkg::LANES; i++)
            begin
                v = longint'(signed'(vals[i]));
                case (lane_fn[i])
                    sgba_pkg::FN_SUM, sgba_pkg::FN_AVG: grp_acc[i] = sat_add(grp_acc[i], v);
                    sgba_pkg::FN_MAX: if (v > grp_acc[i]) grp_acc[i] = v;
                    sgba_pkg::FN_MIN: if (v < grp_acc[i]) grp_acc[i] = v;
                    default: ;
                endcase
            end
        end
        if (eos)
        begin
            queue_group(close_group(1'b1));
            grp_open = 1'b0;
        end
    endtask

    // leaves tvalid high after the request is taken; an idle wait in the next call,
    // or settle, lowers it at the following falling edge
    task automatic send_row(logic [63:0] key, logic [31:0] vals [sgba_pkg::LANES], logic eos);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {vals[3], vals[2], vals[1], vals[0], key};
        s_tlast  = eos;
        do
            @(posedge clk);
        while (!s_tready);
        fold_row(key, vals, eos);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_groups.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_lane_fn(int lane, logic [sgba_pkg::FN_BITS-1:0] fn);
        settle();
        cfg_we    = 1'b1;
        cfg_index = lane[sgba_pkg::CFG_IDX_BITS-1:0];
        cfg_data  = fn;
        @(negedge clk);
        cfg_we = 1'b0;
        lane_fn[lane] = fn;
    endtask

    task automatic set_all_fn(logic [sgba_pkg::FN_BITS-1:0] f0, logic [sgba_pkg::FN_BITS-1:0] f1,
                              logic [sgba_pkg::FN_BITS-1:0] f2, logic [sgba_pkg::FN_BITS-1:0] f3);
        set_lane_fn(0, f0);
        set_lane_fn(1, f1);
        set_lane_fn(2, f2);
        set_lane_fn(3, f3);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [sgba_pkg::FN_BITS-1:0] pick_fn();
        return ($urandom_range(9) == 0) ? sgba_pkg::FN_BITS'($urandom_range(7))
                                        : sgba_pkg::FN_BITS'($urandom_range(4));
    endfunction

    // compare each taken result with the oldest pending group
    always @(posedge clk)
    begin
        group_result_t g;
        logic bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_groups.size() == 0)
            begin
                fail_cnt++;
                if (mismatches++ < 10)
                    $display("unexpected group result: key %h", m_tdata[63:0]);
            end
            else
            begin
                g = pending_groups.pop_front();
                bad = (m_tdata[63:0] !== g.key) || (m_tdata[95:64] !== g.rows)
                      || (m_tlast !== g.last);
                for (int i = 0; i < sgba_pkg::LANES; i++)
                    if (m_tdata[96 + 64*i +: 64] !== g.lane_res[i])
                        bad = 1'b1;
                if (bad)
                begin
                    fail_cnt++;
                    if (mismatches++ < 10)
                        $display({"group mismatch: exp key %h rows %0d lanes %0d %0d %0d %0d",
                                  " last %b\n  got key %h rows %0d lanes %0d %0d %0d %0d",
                                  " last %b"},
                                 g.key, g.rows, g.lane_res[0], g.lane_res[1],
                                 g.lane_res[2], g.lane_res[3], g.last,
                                 m_tdata[63:0], m_tdata[95:64],
                                 $signed(m_tdata[159:96]), $signed(m_tdata[223:160]),
                                 $signed(m_tdata[287:224]), $signed(m_tdata[351:288]),
                                 m_tlast);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_directed();
        logic [31:0] v [sgba_pkg::LANES];
        set_all_fn(sgba_pkg::FN_SUM, sgba_pkg::FN_AVG, sgba_pkg::FN_MAX, sgba_pkg::FN_MIN);
        v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        send_row(64'h0, v, 1'b0);
        v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_row(64'h0, v, 1'b0);
        v = '{32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'h0, 32'h1};
        send_row(64'h0, v, 1'b0);
        // key change and end of stream on the same row: two groups
        v = '{32'h8000_0000, 32'hFFFF_FFF9, 32'h5, 32'hFFFF_FFFF};
        send_row(64'hFFFF_FFFF_FFFF_FFFF, v, 1'b1);
        // single-row group closed by end of stream
        v = '{32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_row(64'h8000_0000_0000_0001, v, 1'b1);
        // negative mean truncates toward zero
        v = '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h3, 32'h3};
        send_row(64'h1, v, 1'b0);
        v = '{32'h0, 32'h0, 32'h2, 32'h4};
        send_row(64'h1, v, 1'b0);
        v = '{32'h0, 32'h0, 32'h2, 32'h4};
        send_row(64'h1, v, 1'b0);
        send_row(64'h2, v, 1'b0);
        set_all_fn(sgba_pkg::FN_COUNT, sgba_pkg::FN_OFF, FN_SPARE6, FN_SPARE7);
        send_row(64'h2, v, 1'b0);
        // switch lanes while a group is still open
        set_all_fn(sgba_pkg::FN_AVG, sgba_pkg::FN_SUM, sgba_pkg::FN_MIN, sgba_pkg::FN_MAX);
        v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FF00, 32'h100};
        send_row(64'h2, v, 1'b0);
        set_all_fn(sgba_pkg::FN_MAX, sgba_pkg::FN_MIN, sgba_pkg::FN_COUNT, sgba_pkg::FN_AVG);
        send_row(64'h2, v, 1'b1);
    endtask

    task automatic test_random(int rows_wanted);
        logic [31:0] v [sgba_pkg::LANES];
        logic [63:0] key;
        int sent, len;
        bit eos;
        sent = 0;
        key  = {$urandom, $urandom};
        while (sent < rows_wanted)
        begin
            if ($urandom_range(19) == 0)
                set_all_fn(pick_fn(), pick_fn(), pick_fn(), pick_fn());
            len = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
            case ($urandom_range(5))
                0:       key = {$urandom, $urandom};
                1:       key = ~key;
                default: key = key + 1;
            endcase
            for (int r = 0; r < len; r++)
            begin
                foreach (v[i])
                    v[i] = pick_value();
                eos = (r == len - 1) ? ($urandom_range(9) == 0) : ($urandom_range(60) == 0);
                send_row(key, v, eos);
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        logic [31:0] v [sgba_pkg::LANES];
        set_all_fn(sgba_pkg::FN_AVG, sgba_pkg::FN_AVG, sgba_pkg::FN_SUM, sgba_pkg::FN_COUNT);
        @(negedge clk);
        hold_cycles = 3000;
        for (int r = 0; r < 40; r++)
        begin
            foreach (v[i])
                v[i] = pick_value();
            send_row(64'(r / 2), v, r == 39);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_cycles = 0;
        mismatches = 0;
        fail_cnt = 0;
        grp_open = 1'b0;
        grp_key = '0;
        grp_rows = '0;
        for (int i = 0; i < sgba_pkg::LANES; i++)
        begin
            lane_fn[i] = sgba_pkg::FN_OFF;
            grp_acc[i] = 0;
        end
        send_idle_pct = 7;
        recv_idle_pct = 68;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(380);
        send_idle_pct = 68;
        recv_idle_pct = 7;
        test_random(380);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(380);

        settle();
        if (fail_cnt == 0)
            $display("[sorted_group_by_aggregator] OK");
        else
            $display("[sorted_group_by_aggregator] ERROR");
        $finish;
    end
endmodule
